### rtl/bine_pkg.sv
package bine_pkg;

  // Request codes
  localparam logic [3:0] REQ_CLEAR   = 4'd0;
  localparam logic [3:0] REQ_ROUTE   = 4'd1;
  localparam logic [3:0] REQ_FIND    = 4'd2;
  localparam logic [3:0] REQ_READ    = 4'd3;
  localparam logic [3:0] REQ_WRKEY   = 4'd4;
  localparam logic [3:0] REQ_INSERT  = 4'd5;
  localparam logic [3:0] REQ_REMOVE  = 4'd6;
  localparam logic [3:0] REQ_ROOT    = 4'd7;
  localparam logic [3:0] REQ_APPEND  = 4'd8;
  localparam logic [3:0] REQ_PREPEND = 4'd9;
  localparam logic [3:0] REQ_SPLIT   = 4'd10;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  // Datapath commands
  typedef enum logic [2:0] {
    DP_NONE,
    DP_RD,       // register read of entry at addr
    DP_WR_KEY,   // write key at addr
    DP_WR_CHILD, // write child at addr
    DP_WR_BOTH,  // write key and child at addr
    DP_MOVE      // write held entry at addr
  } dp_op_e;

  typedef struct packed {
    dp_op_e        op;
    logic [5:0]    addr;
    logic          use_new_child;
  } dp_cmd_t;

endpackage

### rtl/bine_if.sv
interface bine_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [63:0] search_key;
  logic [30:0] child_ref;
  logic [30:0] new_child;
  logic [5:0]  slot;
  modport source (output valid, req_type, search_key, child_ref, new_child, slot,
                  input ready);
  modport sink (input valid, req_type, search_key, child_ref, new_child, slot,
                output ready);
endinterface

interface bine_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] out_child;
  logic [63:0] out_key;
  logic [5:0]  out_slot;
  logic [6:0]  entry_count;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, out_child, out_key, out_slot, entry_count, status, last,
                  input ready);
  modport sink (input valid, out_child, out_key, out_slot, entry_count, status, last,
                output ready);
endinterface

### rtl/btree_internal_node_engine_top.sv
// Channel | Dir | Payload                                        | Handshake
// req     | in  | req_type, search_key, child_ref, new_child, slot | valid/ready
// rsp     | out | out_child, out_key, out_slot, entry_count, status, last | valid/ready
//
// One request at a time. Route, find and insert scan entries in order, reading then comparing each;
// insert, remove and prepend shift entries with a read and then a move of each through the
// one-port key and child memories, which share one command.
// Split returns one result per moved entry.
// Reset clears the entry count and control registers; stored entries are undefined until written.
// A stalled result holds the sequencer before its next result and the next request.
module btree_internal_node_engine_top #(
  parameter int unsigned NODE_ENTRIES = 64,
  parameter int unsigned KEY_BITS     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bine_req_if.sink   req,
  bine_rsp_if.source rsp
);

  bine_pkg::dp_cmd_t   cmd;
  logic [KEY_BITS-1:0] wr_key, rd_key;
  logic [30:0]         wr_child, rd_child;

  bine_ctrl #(.NODE_ENTRIES(NODE_ENTRIES), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk_i, .rst_ni, .req, .rsp,
    .cmd_o(cmd), .wr_key_o(wr_key), .wr_child_o(wr_child),
    .rd_key_i(rd_key), .rd_child_i(rd_child)
  );

  bine_datapath #(.NODE_ENTRIES(NODE_ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i, .cmd_i(cmd), .wr_key_i(wr_key), .wr_child_i(wr_child),
    .rd_key_o(rd_key), .rd_child_o(rd_child)
  );

  // Count never exceeds node capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.entry_count <= 7'(NODE_ENTRIES))
    else $error("entry count beyond capacity");

  // Hold a waiting result until it transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> rsp.valid)
    else $error("result dropped");

  // No new request taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid)
    else $error("request taken over a waiting result");

  // Error results are always last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != bine_pkg::ST_OK) |-> rsp.last)
    else $error("error result not last");

endmodule

### rtl/bine_datapath.sv
module bine_datapath #(
  parameter int unsigned NODE_ENTRIES = 64,
  parameter int unsigned KEY_BITS     = 64
) (
  input  logic                   clk_i,
  input  bine_pkg::dp_cmd_t      cmd_i,
  input  logic [KEY_BITS-1:0]    wr_key_i,
  input  logic [30:0]            wr_child_i,
  output logic [KEY_BITS-1:0]    rd_key_o,
  output logic [30:0]            rd_child_o
);

  localparam int unsigned AW = $clog2(NODE_ENTRIES);

  logic [KEY_BITS-1:0] key_mem [NODE_ENTRIES];
  logic [30:0]         child_mem [NODE_ENTRIES];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [30:0]         rd_child_q;
  logic [AW-1:0]       addr;

  assign addr = cmd_i.addr[AW-1:0];

  // Key memory: one port, registered read
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bine_pkg::DP_RD: rd_key_q <= key_mem[addr];
      bine_pkg::DP_WR_KEY, bine_pkg::DP_WR_BOTH: key_mem[addr] <= wr_key_i;
      bine_pkg::DP_MOVE: key_mem[addr] <= rd_key_q;
      default: ;
    endcase
  end

  // Child memory: one port, registered read
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bine_pkg::DP_RD: rd_child_q <= child_mem[addr];
      bine_pkg::DP_WR_CHILD, bine_pkg::DP_WR_BOTH: child_mem[addr] <= wr_child_i;
      bine_pkg::DP_MOVE: child_mem[addr] <= rd_child_q;
      default: ;
    endcase
  end

  assign rd_key_o   = rd_key_q;
  assign rd_child_o = rd_child_q;

endmodule

### rtl/bine_ctrl.sv
module bine_ctrl #(
  parameter int unsigned NODE_ENTRIES = 64,
  parameter int unsigned KEY_BITS     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bine_req_if.sink            req,
  bine_rsp_if.source          rsp,
  output bine_pkg::dp_cmd_t   cmd_o,
  output logic [KEY_BITS-1:0] wr_key_o,
  output logic [30:0]         wr_child_o,
  input  logic [KEY_BITS-1:0] rd_key_i,
  input  logic [30:0]         rd_child_i
);

  localparam logic [6:0] FULL = 7'(NODE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_INS_WR, S_ROOT2, S_SPLIT_RD, S_SPLIT_OUT, S_READ_WAIT, S_RESP
  } state_e;

  state_e              state_q;
  logic [3:0]          req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [30:0]         cref_q, nchild_q;
  logic [5:0]          slot_q;
  logic [6:0]          cnt_q;
  logic [6:0]          idx_q;   // scan / shift position
  logic [6:0]          stop_q;  // shift end position
  logic [30:0]         prev_child_q;
  bine_pkg::dp_cmd_t   cmd_q;
  logic                ov_q;
  logic [30:0]         o_child_q;
  logic [63:0]         o_key_q;
  logic [5:0]          o_slot_q;
  logic [1:0]          o_st_q;
  logic                o_last_q;

  // Take a new request only once the previous result has transferred
  assign req.ready       = (state_q == S_IDLE) && !ov_q;
  assign rsp.valid       = ov_q;
  assign rsp.out_child   = o_child_q;
  assign rsp.out_key     = o_key_q;
  assign rsp.out_slot    = o_slot_q;
  assign rsp.entry_count = cnt_q;
  assign rsp.status      = o_st_q;
  assign rsp.last        = o_last_q;
  assign cmd_o           = cmd_q;
  assign wr_key_o        = key_q;
  assign wr_child_o      = (cmd_q.use_new_child) ? nchild_q : cref_q;

  // Sequencer: scans, shifts and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      cmd_q    <= '{op: bine_pkg::DP_NONE, addr: '0, use_new_child: 1'b0};
      req_q    <= '0;
      key_q    <= '0;
      cref_q   <= '0;
      nchild_q <= '0;
      slot_q   <= '0;
      idx_q    <= '0;
      stop_q   <= '0;
      prev_child_q <= '0;
      o_child_q <= '0;
      o_key_q   <= '0;
      o_slot_q  <= '0;
      o_st_q    <= '0;
      o_last_q  <= 1'b0;
    end else begin
      cmd_q.op <= bine_pkg::DP_NONE;
      if (rsp.valid && rsp.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q    <= req.req_type;
            key_q    <= req.search_key[KEY_BITS-1:0];
            cref_q   <= req.child_ref;
            nchild_q <= req.new_child;
            slot_q   <= req.slot;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          o_child_q <= '0;
          o_key_q   <= '0;
          o_slot_q  <= '0;
          o_st_q    <= bine_pkg::ST_OK;
          o_last_q  <= 1'b1;
          idx_q     <= '0;
          state_q   <= S_RESP;
          case (req_q)
            bine_pkg::REQ_CLEAR: cnt_q <= '0;
            bine_pkg::REQ_ROUTE, bine_pkg::REQ_FIND: begin
              if (req_q == bine_pkg::REQ_ROUTE && cnt_q == 7'd0) begin
                o_st_q <= bine_pkg::ST_BAD;
              end else if (req_q == bine_pkg::REQ_FIND && cnt_q == 7'd0) begin
                o_st_q <= bine_pkg::ST_NOTFOUND;
              end else begin
                cmd_q   <= '{op: bine_pkg::DP_RD, addr: 6'd0, use_new_child: 1'b0};
                state_q <= S_SCAN_RD;
              end
            end
            bine_pkg::REQ_READ, bine_pkg::REQ_WRKEY, bine_pkg::REQ_REMOVE: begin
              if ({1'b0, slot_q} >= cnt_q) begin
                o_st_q <= bine_pkg::ST_BAD;
              end else if (req_q == bine_pkg::REQ_READ) begin
                cmd_q   <= '{op: bine_pkg::DP_RD, addr: slot_q, use_new_child: 1'b0};
                state_q <= S_READ_WAIT;
              end else if (req_q == bine_pkg::REQ_WRKEY) begin
                cmd_q <= '{op: bine_pkg::DP_WR_KEY, addr: slot_q, use_new_child: 1'b0};
              end else begin
                // shift down from slot+1 to cnt-1
                idx_q   <= {1'b0, slot_q} + 7'd1;
                stop_q  <= cnt_q;
                state_q <= S_SHIFT_RD;
              end
            end
            bine_pkg::REQ_INSERT: begin
              if (cnt_q >= FULL) o_st_q <= bine_pkg::ST_FULL;
              else begin
                cmd_q   <= '{op: bine_pkg::DP_RD, addr: 6'd0, use_new_child: 1'b0};
                state_q <= (cnt_q == 7'd0) ? S_RESP : S_SCAN_RD;
                if (cnt_q == 7'd0) o_st_q <= bine_pkg::ST_NOTFOUND;
              end
            end
            bine_pkg::REQ_ROOT: begin
              cmd_q   <= '{op: bine_pkg::DP_WR_CHILD, addr: 6'd0, use_new_child: 1'b0};
              state_q <= S_ROOT2;
            end
            bine_pkg::REQ_APPEND: begin
              if (cnt_q >= FULL) o_st_q <= bine_pkg::ST_FULL;
              else begin
                cmd_q <= '{op: bine_pkg::DP_WR_BOTH, addr: cnt_q[5:0], use_new_child: 1'b0};
                cnt_q <= cnt_q + 7'd1;
              end
            end
            bine_pkg::REQ_PREPEND: begin
              if (cnt_q >= FULL) o_st_q <= bine_pkg::ST_FULL;
              else begin
                // shift up from cnt down to 1
                idx_q   <= cnt_q;
                stop_q  <= 7'd0;
                state_q <= S_SHIFT_RD;
              end
            end
            bine_pkg::REQ_SPLIT: begin
              if (cnt_q == 7'd0) o_st_q <= bine_pkg::ST_BAD;
              else begin
                idx_q   <= {1'b0, cnt_q[6:1]};
                stop_q  <= cnt_q;
                cnt_q   <= {1'b0, cnt_q[6:1]};
                state_q <= S_SPLIT_RD;
              end
            end
            default: ;
          endcase
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          // compare entry idx with request
          if (req_q == bine_pkg::REQ_ROUTE) begin
            if (idx_q != 7'd0 && key_q < rd_key_i) begin
              o_child_q <= prev_child_q;
              state_q   <= S_RESP;
            end else if (idx_q + 7'd1 >= cnt_q) begin
              o_child_q <= rd_child_i;
              state_q   <= S_RESP;
            end else begin
              prev_child_q <= rd_child_i;
              idx_q   <= idx_q + 7'd1;
              cmd_q   <= '{op: bine_pkg::DP_RD, addr: 6'(idx_q + 7'd1), use_new_child: 1'b0};
              state_q <= S_SCAN_RD;
            end
          end else if (rd_child_i == cref_q) begin
            if (req_q == bine_pkg::REQ_FIND) begin
              o_slot_q <= idx_q[5:0];
              state_q  <= S_RESP;
            end else begin
              // insert at idx+1: shift up from cnt down to idx+2
              stop_q  <= idx_q + 7'd1;
              idx_q   <= cnt_q;
              state_q <= S_SHIFT_RD;
            end
          end else if (idx_q + 7'd1 >= cnt_q) begin
            o_st_q  <= bine_pkg::ST_NOTFOUND;
            state_q <= S_RESP;
          end else begin
            idx_q   <= idx_q + 7'd1;
            cmd_q   <= '{op: bine_pkg::DP_RD, addr: 6'(idx_q + 7'd1), use_new_child: 1'b0};
            state_q <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          if (req_q == bine_pkg::REQ_REMOVE) begin
            if (idx_q >= stop_q) begin
              cnt_q   <= cnt_q - 7'd1;
              state_q <= S_RESP;
            end else begin
              cmd_q   <= '{op: bine_pkg::DP_RD, addr: idx_q[5:0], use_new_child: 1'b0};
              state_q <= S_SHIFT_WR;
            end
          end else if (idx_q <= stop_q || idx_q == 7'd0) begin
            state_q <= S_INS_WR;
          end else begin
            cmd_q   <= '{op: bine_pkg::DP_RD, addr: 6'(idx_q - 7'd1), use_new_child: 1'b0};
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          if (req_q == bine_pkg::REQ_REMOVE) begin
            cmd_q <= '{op: bine_pkg::DP_MOVE, addr: 6'(idx_q - 7'd1), use_new_child: 1'b0};
            idx_q <= idx_q + 7'd1;
          end else begin
            cmd_q <= '{op: bine_pkg::DP_MOVE, addr: idx_q[5:0], use_new_child: 1'b0};
            idx_q <= idx_q - 7'd1;
          end
          state_q <= S_SHIFT_RD;
        end
        S_INS_WR: begin
          cnt_q <= cnt_q + 7'd1;
          if (req_q == bine_pkg::REQ_INSERT) begin
            cmd_q   <= '{op: bine_pkg::DP_WR_BOTH, addr: stop_q[5:0], use_new_child: 1'b1};
            state_q <= S_RESP;
          end else begin
            cmd_q   <= '{op: bine_pkg::DP_WR_CHILD, addr: 6'd0, use_new_child: 1'b0};
            idx_q   <= 7'd1;
            state_q <= S_ROOT2;
          end
        end
        S_ROOT2: begin
          // root: key1/new child at 1; prepend: key1 only
          if (req_q == bine_pkg::REQ_ROOT) begin
            cmd_q <= '{op: bine_pkg::DP_WR_BOTH, addr: 6'd1, use_new_child: 1'b1};
            cnt_q <= 7'd2;
          end else begin
            cmd_q <= '{op: bine_pkg::DP_WR_KEY, addr: 6'd1, use_new_child: 1'b0};
          end
          state_q <= S_RESP;
        end
        S_READ_WAIT: begin
          if (idx_q == 7'd0) idx_q <= 7'd1;
          else begin
            o_child_q <= rd_child_i;
            o_key_q   <= 64'(rd_key_i);
            state_q   <= S_RESP;
          end
        end
        S_SPLIT_RD: begin
          if (!ov_q || rsp.ready) begin
            cmd_q   <= '{op: bine_pkg::DP_RD, addr: idx_q[5:0], use_new_child: 1'b0};
            state_q <= S_SPLIT_OUT;
          end
        end
        S_SPLIT_OUT: begin
          if (cmd_q.op == bine_pkg::DP_NONE) begin
            o_child_q <= rd_child_i;
            o_key_q   <= 64'(rd_key_i);
            o_last_q  <= (idx_q + 7'd1 == stop_q);
            ov_q      <= 1'b1;
            idx_q     <= idx_q + 7'd1;
            state_q   <= (idx_q + 7'd1 == stop_q) ? S_IDLE : S_SPLIT_RD;
          end
        end
        S_RESP: begin
          if (!ov_q || rsp.ready) begin
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
